/* rtl/core/alc_pkg.sv */
// ---------------------------------------------------------------------------
// alc_pkg
// Shared types and constants for the light sensor autorange, lux and CCT block.
// ---------------------------------------------------------------------------
package alc_pkg;

  typedef logic signed [19:0] coef_t;
  typedef logic [15:0]        count_t;

  // count width of one channel sample
  localparam int CNT_BITS = 16;

  // weighted channel sum: |sum| < 2^37, so 38 bits signed
  localparam int WSUM_W = 38;

  // lux divider divisor width (1000 and 504 both fit)
  localparam int LDIV_VW = 10;
  localparam int LDIV_DW = 48;

  // register map (word index)
  localparam logic [2:0] REG_COEFF_RED   = 3'd0;
  localparam logic [2:0] REG_COEFF_GREEN = 3'd1;
  localparam logic [2:0] REG_COEFF_BLUE  = 3'd2;
  localparam logic [2:0] REG_COEFF_CLEAR = 3'd3;
  localparam logic [2:0] REG_DEV_FACTOR  = 3'd4;
  localparam logic [2:0] REG_CCT_COEF    = 3'd5;
  localparam logic [2:0] REG_CCT_OFFSET  = 3'd6;

  localparam coef_t  COEFF_RED_RST   = -20'sd220;
  localparam coef_t  COEFF_GREEN_RST = 20'sd110;
  localparam coef_t  COEFF_BLUE_RST  = -20'sd1120;
  localparam coef_t  COEFF_CLEAR_RST = 20'sd1000;
  localparam count_t DEV_FACTOR_RST  = 16'd831;
  localparam count_t CCT_COEF_RST    = 16'd4091;
  localparam count_t CCT_OFFSET_RST  = 16'd227;

  localparam count_t LOW_CLEAR_LIM  = 16'd25;
  localparam count_t HIGH_CLEAR_LIM = 16'd15000;
  localparam count_t SAT_CLEAR_LIM  = 16'd18500;

  localparam logic [30:0] LUX_AT_SAT = 31'd150000;
  localparam logic [30:0] OUT_MAX    = 31'h7FFF_FFFF;

  localparam logic [LDIV_VW-1:0] WEIGHT_SCALE = 10'd1000;
  // 18 integration steps times 28 per step
  localparam logic [LDIV_VW-1:0] LUX_DIVISOR  = 10'd504;

endpackage

/* rtl/core/alc_serial_div.sv */
// ---------------------------------------------------------------------------
// alc_serial_div
// Restoring radix-2 divider: one quotient bit per cycle.
// ---------------------------------------------------------------------------
module alc_serial_div #(
  parameter int DW = 48,
  parameter int VW = 10
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic          done,
  output logic [DW-1:0] quotient
);

  localparam int CW = (DW > 1) ? $clog2(DW) : 1;

  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [DW-1:0] dvd_r, dvd_nxt;
  logic [VW-1:0] rem_r, rem_nxt;
  logic [VW-1:0] dsr_r, dsr_nxt;
  logic [VW:0]   trial;
  logic [VW:0]   diff;
  logic          take;

  assign trial = {rem_r, dvd_r[DW-1]};
  assign diff  = trial - {1'b0, dsr_r};
  assign take  = (trial >= {1'b0, dsr_r});

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CW'(DW - 1);
      dvd_nxt  = dividend;
      rem_nxt  = '0;
      dsr_nxt  = divisor;
    end else if (busy_r) begin
      // dividend shifts out the top, quotient bits enter at the bottom
      dvd_nxt = {dvd_r[DW-2:0], take};
      rem_nxt = take ? diff[VW-1:0] : trial[VW-1:0];
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
  end

  assign done     = done_r;
  assign quotient = dvd_r;

endmodule

/* rtl/core/alc_serial_mul.sv */
// ---------------------------------------------------------------------------
// alc_serial_mul
// Unsigned shift-add multiplier, multiplier bits taken MSB first.
// ---------------------------------------------------------------------------
module alc_serial_mul #(
  parameter int AW = 28,
  parameter int BW = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [AW-1:0]    a,
  input  logic [BW-1:0]    b,
  output logic             done,
  output logic [AW+BW-1:0] product
);

  localparam int PW = AW + BW;
  localparam int CW = (BW > 1) ? $clog2(BW) : 1;

  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [AW-1:0] a_r, a_nxt;
  logic [BW-1:0] b_r, b_nxt;
  logic [PW-1:0] p_r, p_nxt;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    a_nxt    = a_r;
    b_nxt    = b_r;
    p_nxt    = p_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CW'(BW - 1);
      a_nxt    = a;
      b_nxt    = b;
      p_nxt    = '0;
    end else if (busy_r) begin
      p_nxt = {p_r[PW-2:0], 1'b0} + (b_r[BW-1] ? PW'(a_r) : '0);
      b_nxt = b_r << 1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r <= a_nxt;
    b_r <= b_nxt;
    p_r <= p_nxt;
  end

  assign done    = done_r;
  assign product = p_r;

endmodule

/* rtl/core/alc_wsum.sv */
// ---------------------------------------------------------------------------
// alc_wsum
// Bit-serial signed weighted sum of the four channel counts, one count bit of
// every channel per cycle, MSB first.
// ---------------------------------------------------------------------------
module alc_wsum (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  alc_pkg::count_t      clear_count,
  input  alc_pkg::count_t      red_count,
  input  alc_pkg::count_t      green_count,
  input  alc_pkg::count_t      blue_count,
  input  alc_pkg::coef_t       coeff_red,
  input  alc_pkg::coef_t       coeff_green,
  input  alc_pkg::coef_t       coeff_blue,
  input  alc_pkg::coef_t       coeff_clear,
  output logic                 done,
  output logic signed [alc_pkg::WSUM_W-1:0] sum
);

  import alc_pkg::*;

  localparam int CW = $clog2(CNT_BITS);

  logic                     busy_r, busy_nxt;
  logic                     done_r, done_nxt;
  logic [CW-1:0]            cnt_r, cnt_nxt;
  count_t                   c_r, c_nxt, r_r, r_nxt, g_r, g_nxt, b_r, b_nxt;
  logic signed [WSUM_W-1:0] acc_r, acc_nxt;
  logic signed [21:0]       t_c, t_r, t_g, t_b, digit;

  always_comb begin
    t_c   = c_r[CNT_BITS-1] ? 22'(coeff_clear) : '0;
    t_r   = r_r[CNT_BITS-1] ? 22'(coeff_red)   : '0;
    t_g   = g_r[CNT_BITS-1] ? 22'(coeff_green) : '0;
    t_b   = b_r[CNT_BITS-1] ? 22'(coeff_blue)  : '0;
    digit = t_c + t_r + t_g + t_b;
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    c_nxt    = c_r;
    r_nxt    = r_r;
    g_nxt    = g_r;
    b_nxt    = b_r;
    acc_nxt  = acc_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CW'(CNT_BITS - 1);
      c_nxt    = clear_count;
      r_nxt    = red_count;
      g_nxt    = green_count;
      b_nxt    = blue_count;
      acc_nxt  = '0;
    end else if (busy_r) begin
      acc_nxt = (acc_r <<< 1) + WSUM_W'(digit);
      c_nxt   = c_r << 1;
      r_nxt   = r_r << 1;
      g_nxt   = g_r << 1;
      b_nxt   = b_r << 1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    c_r   <= c_nxt;
    r_r   <= r_nxt;
    g_r   <= g_nxt;
    b_r   <= b_nxt;
    acc_r <= acc_nxt;
  end

  assign done = done_r;
  assign sum  = acc_r;

endmodule

/* rtl/core/als_autorange_lux_cct_unit.sv */
// ---------------------------------------------------------------------------
// als_autorange_lux_cct_unit
// Light sensor gain autorange with lux and color temperature calculation.
// ---------------------------------------------------------------------------
// One clear/red/green/blue sample in, one result out. A sample that falls
// outside the range of the current gain on a first attempt flips the gain and
// offers a remeasure result (tuser high) through the ST_FIN state and the
// output register. Any other sample is worked bit-serially: a weighted channel
// sum, a divide by 1000, a multiply by the device factor and by ten, and a
// divide by 504, each step started as the last one signals done; this serial
// lux chain sets when a result is offered and when a new sample is taken.
// Color temperature runs alongside on its own multiplier and divider and is
// ready long before the lux chain ends. One sample is worked at a time; the
// output register holds a result while the next sample is taken. Registers
// must be written only while the block is idle; the block does not enforce it.
module als_autorange_lux_cct_unit (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // clear_count, red_count, green_count, blue_count
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // gain_sel, lux, color_temp, color_temp_valid
  output logic        out_tuser,  // remeasure
  // register port
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  import alc_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SUM  = 3'd1;
  localparam logic [2:0] ST_DIV1 = 3'd2;
  localparam logic [2:0] ST_MUL  = 3'd3;
  localparam logic [2:0] ST_DIV2 = 3'd4;
  localparam logic [2:0] ST_FIN  = 3'd5;

  // configuration registers
  coef_t  coeff_red_r, coeff_green_r, coeff_blue_r, coeff_clear_r;
  count_t dev_factor_r, cct_coef_r, cct_offset_r;
  logic   cfg_we;
  logic [2:0] cfg_idx;

  // control
  logic [2:0] state_r, state_nxt;
  logic       gain_high_r, gain_high_nxt;
  logic       retried_r, retried_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       cct_done_r, cct_done_nxt;

  // item payload
  count_t clr_r, clr_nxt;
  count_t red_r, red_nxt;
  logic   gain_item_r, gain_item_nxt;
  logic   remeas_r, remeas_nxt;

  // output payload
  logic        out_remeas_r, out_remeas_nxt;
  logic        out_gain_r, out_gain_nxt;
  logic [30:0] out_lux_r, out_lux_nxt;
  logic [30:0] out_cct_r, out_cct_nxt;
  logic        out_cctv_r, out_cctv_nxt;

  count_t in_clr, in_red, in_green, in_blue;
  logic   in_xfer;
  logic   remeas_now;

  // datapath units
  logic                      wsum_start, wsum_done;
  logic signed [WSUM_W-1:0]  wsum;
  logic                      ldiv_start, ldiv_done;
  logic [LDIV_DW-1:0]        ldiv_dvd, ldiv_q;
  logic [LDIV_VW-1:0]        ldiv_dsr;
  logic                      lmul_start, lmul_done;
  logic [43:0]               lmul_p;
  logic [LDIV_DW-1:0]        lmul_p10;
  logic                      sum_pos;
  logic                      cmul_done;
  logic [31:0]               cmul_p;
  logic                      cdiv_done;
  logic [31:0]               cdiv_q;

  logic [LDIV_DW-1:0] lux_q;
  logic [30:0]        lux_val;
  logic [32:0]        cct_sum;
  logic [30:0]        cct_val;

  assign in_clr   = in_tdata[15:0];
  assign in_red   = in_tdata[31:16];
  assign in_green = in_tdata[47:32];
  assign in_blue  = in_tdata[63:48];

  assign in_tready = (state_r == ST_IDLE);
  assign in_xfer   = in_tvalid & in_tready;

  assign remeas_now = !retried_r &&
                      ((!gain_high_r && (in_clr < LOW_CLEAR_LIM)) ||
                       (gain_high_r && (in_clr > HIGH_CLEAR_LIM)));

  // ---- register port ----
  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[4:2];
  assign cfg_we     = cfg_psel & cfg_penable & cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coeff_red_r   <= COEFF_RED_RST;
      coeff_green_r <= COEFF_GREEN_RST;
      coeff_blue_r  <= COEFF_BLUE_RST;
      coeff_clear_r <= COEFF_CLEAR_RST;
      dev_factor_r  <= DEV_FACTOR_RST;
      cct_coef_r    <= CCT_COEF_RST;
      cct_offset_r  <= CCT_OFFSET_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_COEFF_RED:   coeff_red_r   <= cfg_pwdata[19:0];
        REG_COEFF_GREEN: coeff_green_r <= cfg_pwdata[19:0];
        REG_COEFF_BLUE:  coeff_blue_r  <= cfg_pwdata[19:0];
        REG_COEFF_CLEAR: coeff_clear_r <= cfg_pwdata[19:0];
        REG_DEV_FACTOR:  dev_factor_r  <= cfg_pwdata[15:0];
        REG_CCT_COEF:    cct_coef_r    <= cfg_pwdata[15:0];
        REG_CCT_OFFSET:  cct_offset_r  <= cfg_pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_COEFF_RED:   cfg_prdata = {12'd0, coeff_red_r};
      REG_COEFF_GREEN: cfg_prdata = {12'd0, coeff_green_r};
      REG_COEFF_BLUE:  cfg_prdata = {12'd0, coeff_blue_r};
      REG_COEFF_CLEAR: cfg_prdata = {12'd0, coeff_clear_r};
      REG_DEV_FACTOR:  cfg_prdata = {16'd0, dev_factor_r};
      REG_CCT_COEF:    cfg_prdata = {16'd0, cct_coef_r};
      REG_CCT_OFFSET:  cfg_prdata = {16'd0, cct_offset_r};
      default:         cfg_prdata = '0;
    endcase
  end

  // ---- units ----
  assign wsum_start = in_xfer & !remeas_now;

  alc_wsum u_wsum (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (wsum_start),
    .clear_count (in_clr),
    .red_count   (in_red),
    .green_count (in_green),
    .blue_count  (in_blue),
    .coeff_red   (coeff_red_r),
    .coeff_green (coeff_green_r),
    .coeff_blue  (coeff_blue_r),
    .coeff_clear (coeff_clear_r),
    .done        (wsum_done),
    .sum         (wsum)
  );

  // a non-positive sum gives zero lux unless the clear count saturates; a zero dividend carries that through
  assign sum_pos  = !wsum[WSUM_W-1] && (wsum != '0);
  assign lmul_p10 = LDIV_DW'({lmul_p, 3'b000}) + LDIV_DW'({lmul_p, 1'b0});

  assign ldiv_start = ((state_r == ST_SUM) && wsum_done) ||
                      ((state_r == ST_MUL) && lmul_done);
  assign ldiv_dvd   = (state_r == ST_SUM) ?
                      (sum_pos ? LDIV_DW'(wsum[WSUM_W-2:0]) : '0) : lmul_p10;
  assign ldiv_dsr   = (state_r == ST_SUM) ? WEIGHT_SCALE : LUX_DIVISOR;

  alc_serial_div #(.DW(LDIV_DW), .VW(LDIV_VW)) u_lux_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (ldiv_start),
    .dividend (ldiv_dvd),
    .divisor  (ldiv_dsr),
    .done     (ldiv_done),
    .quotient (ldiv_q)
  );

  // weighted sum / 1000 stays below 2^28
  assign lmul_start = (state_r == ST_DIV1) && ldiv_done;

  alc_serial_mul #(.AW(28), .BW(16)) u_lux_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (lmul_start),
    .a       (ldiv_q[27:0]),
    .b       (dev_factor_r),
    .done    (lmul_done),
    .product (lmul_p)
  );

  alc_serial_mul #(.AW(16), .BW(16)) u_cct_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (wsum_start),
    .a       (cct_coef_r),
    .b       (in_blue),
    .done    (cmul_done),
    .product (cmul_p)
  );

  alc_serial_div #(.DW(32), .VW(16)) u_cct_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmul_done),
    .dividend (cmul_p),
    .divisor  (red_r),
    .done     (cdiv_done),
    .quotient (cdiv_q)
  );

  // ---- result formatting ----
  always_comb begin
    lux_q = gain_item_r ? (ldiv_q >> 4) : ldiv_q;
    if (!gain_item_r && (clr_r >= SAT_CLEAR_LIM)) begin
      lux_val = LUX_AT_SAT;
    end else if (|lux_q[LDIV_DW-1:31]) begin
      lux_val = OUT_MAX;
    end else begin
      lux_val = lux_q[30:0];
    end
    cct_sum = 33'(cdiv_q) + 33'(cct_offset_r);
    cct_val = (|cct_sum[32:31]) ? OUT_MAX : cct_sum[30:0];
  end

  // ---- sequencer ----
  always_comb begin
    state_nxt      = state_r;
    gain_high_nxt  = gain_high_r;
    retried_nxt    = retried_r;
    out_valid_nxt  = out_valid_r;
    cct_done_nxt   = cct_done_r;
    clr_nxt        = clr_r;
    red_nxt        = red_r;
    gain_item_nxt  = gain_item_r;
    remeas_nxt     = remeas_r;
    out_remeas_nxt = out_remeas_r;
    out_gain_nxt   = out_gain_r;
    out_lux_nxt    = out_lux_r;
    out_cct_nxt    = out_cct_r;
    out_cctv_nxt   = out_cctv_r;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    if (wsum_start) begin
      cct_done_nxt = 1'b0;
    end else if (cdiv_done) begin
      cct_done_nxt = 1'b1;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          clr_nxt       = in_clr;
          red_nxt       = in_red;
          gain_item_nxt = gain_high_r;
          remeas_nxt    = remeas_now;
          if (remeas_now) begin
            gain_high_nxt = !gain_high_r;
            retried_nxt   = 1'b1;
            state_nxt     = ST_FIN;
          end else begin
            retried_nxt = 1'b0;
            state_nxt   = ST_SUM;
          end
        end
      end
      ST_SUM: begin
        if (wsum_done) begin
          state_nxt = ST_DIV1;
        end
      end
      ST_DIV1: begin
        if (ldiv_done) begin
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        if (lmul_done) begin
          state_nxt = ST_DIV2;
        end
      end
      ST_DIV2: begin
        if (ldiv_done) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if ((remeas_r || cct_done_r) && (!out_valid_r || out_tready)) begin
          out_valid_nxt  = 1'b1;
          out_remeas_nxt = remeas_r;
          out_gain_nxt   = gain_high_r;
          if (remeas_r) begin
            out_lux_nxt  = '0;
            out_cct_nxt  = '0;
            out_cctv_nxt = 1'b0;
          end else begin
            out_lux_nxt  = lux_val;
            out_cct_nxt  = (red_r == '0) ? '0 : cct_val;
            out_cctv_nxt = (red_r != '0);
          end
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      gain_high_r <= 1'b1;
      retried_r   <= 1'b0;
      out_valid_r <= 1'b0;
      cct_done_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      gain_high_r <= gain_high_nxt;
      retried_r   <= retried_nxt;
      out_valid_r <= out_valid_nxt;
      cct_done_r  <= cct_done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    clr_r        <= clr_nxt;
    red_r        <= red_nxt;
    gain_item_r  <= gain_item_nxt;
    remeas_r     <= remeas_nxt;
    out_remeas_r <= out_remeas_nxt;
    out_gain_r   <= out_gain_nxt;
    out_lux_r    <= out_lux_nxt;
    out_cct_r    <= out_cct_nxt;
    out_cctv_r   <= out_cctv_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_remeas_r;
  assign out_tdata  = {out_cctv_r, out_cct_r, out_lux_r, out_gain_r};

endmodule
